// File: hdl/pixel_brightness_scaler_macros.svh
// Assertion macros shared by the brightness scaler RTL.
`ifndef PIXEL_BRIGHTNESS_SCALER_MACROS_SVH
`define PIXEL_BRIGHTNESS_SCALER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PBS_ASSERT_NOW(label, clk_i, rstn_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error("pbs assertion failed");

// Next-cycle implication, checked out of reset.
`define PBS_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error("pbs assertion failed");

`endif

// File: hdl/pbs_pkg.sv
// Shared types, codes and channel arithmetic for the brightness scaler.
`default_nettype none
package pbs_pkg;

	localparam int unsigned PixW  = 32;
	localparam int unsigned GainW = 11;
	localparam int unsigned CubeW = 8;
	localparam int unsigned ChanW = 8;

	// Register indexes on the config port
	localparam logic [0:0] RegFormat = 1'b0;
	localparam logic [0:0] RegGain   = 1'b1;

	localparam logic [GainW-1:0] GainReset = 11'd256;

	typedef enum logic [1:0] {
		FMT_32 = 2'd0,
		FMT_24 = 2'd1,
		FMT_16 = 2'd2
	} pix_fmt_t;

	// Three color channels, channel 0 in the low byte
	typedef logic [2:0][ChanW-1:0] chan3_t;

	// Q8 gain, truncate, clamp to lim
	function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] v,
			input logic [GainW-1:0] g, input logic [ChanW-1:0] lim);
		logic [ChanW+GainW-1:0] prod;
		logic [GainW-1:0] c;
		prod = {{GainW{1'b0}}, v} * {{ChanW{1'b0}}, g};
		c = prod[ChanW+GainW-1:8];
		return (c > {3'b000, lim}) ? lim : c[ChanW-1:0];
	endfunction

	// (v+25)/51 written as threshold compares; range 0..5
	function automatic logic [2:0] cube_digit(input logic [ChanW-1:0] v);
		logic [2:0] d;
		d = 3'd0;
		if (v >= 8'd26)  d = 3'd1;
		if (v >= 8'd77)  d = 3'd2;
		if (v >= 8'd128) d = 3'd3;
		if (v >= 8'd179) d = 3'd4;
		if (v >= 8'd230) d = 3'd5;
		return d;
	endfunction

endpackage
`default_nettype wire

// File: hdl/pbs_scale.sv
// Channel extraction and gain/saturation for one pixel word.
`default_nettype none
module pbs_scale import pbs_pkg::*; (
	input  var pix_fmt_t         fmt,
	input  wire  [GainW-1:0]     gain,
	input  wire  [PixW-1:0]      pixel,
	output chan3_t               ch
);

	chan3_t raw;
	chan3_t lim;

	// 565 fields share the byte datapath, zero-extended
	always_comb begin
		case (fmt)
			FMT_16: begin
				raw[0] = {3'b000, pixel[4:0]};
				raw[1] = {2'b00, pixel[10:5]};
				raw[2] = {3'b000, pixel[15:11]};
				lim[0] = 8'h1f;
				lim[1] = 8'h3f;
				lim[2] = 8'h1f;
			end
			default: begin
				raw[0] = pixel[7:0];
				raw[1] = pixel[15:8];
				raw[2] = pixel[23:16];
				lim[0] = 8'hff;
				lim[1] = 8'hff;
				lim[2] = 8'hff;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ch[i] = scale_chan(raw[i], gain, lim[i]);
		end
	end

endmodule
`default_nettype wire

// File: hdl/pbs_cube.sv
// 6x6x6 color-cube index from three scaled bytes.
`default_nettype none
module pbs_cube import pbs_pkg::*; (
	input  var pix_fmt_t         fmt,
	input  var chan3_t           ch,
	output logic [CubeW-1:0]     cube
);

	logic [2:0] d0, d1, d2;
	logic [CubeW-1:0] idx;

	assign d0 = cube_digit(ch[0]);
	assign d1 = cube_digit(ch[1]);
	assign d2 = cube_digit(ch[2]);

	// d0*36 + d1*6 + d2 as shifts and adds
	assign idx = ({5'b0, d0} << 5) + ({5'b0, d0} << 2)
	           + ({5'b0, d1} << 2) + ({5'b0, d1} << 1) + {5'b0, d2};

	assign cube = (fmt == FMT_24) ? idx : '0;

endmodule
`default_nettype wire

// File: hdl/pixel_brightness_scaler.sv
// Top level: pixel brightness gain with per-channel saturation and cube index.
//
//  channel   dir  signals                          payload
//  s_*       in   s_tvalid s_tready s_tdata[31:0]  pixel_in
//  m_*       out  m_tvalid m_tready m_tdata[39:0]  pixel_out, cube_index
//  cfg_*     in   cfg_we cfg_addr cfg_wdata[10:0]  0 pixel_format, 1 gain
//
// Three-stage pipeline: input register, scaled-channel register, output register.
// One pixel per clock sustained while m_tready does not stall; m_tvalid rises once the
// input transfer has passed through the vld_s1, vld_s2 and vld_s3 registers.
// The gain multipliers (three 8x11) set the critical path from stage 1 into stage 2.
// All stages advance together when the output register is empty or drained, so a
// stall on m_tready holds the whole pipe and drops s_tready.
// arst_n clears the valid bits and loads pixel_format=0, gain=256.
`default_nettype none
`include "pixel_brightness_scaler_macros.svh"
module pixel_brightness_scaler import pbs_pkg::*; (
	input  wire              clk,
	input  wire              arst_n,
	// slave stream
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [31:0]      s_tdata,   // [31:0] pixel_in
	// master stream
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [39:0]      m_tdata,   // [31:0] pixel_out, [39:32] cube_index
	// config write port
	input  wire              cfg_we,
	input  wire  [0:0]       cfg_addr,
	input  wire  [GainW-1:0] cfg_wdata
);

	// Config registers
	pix_fmt_t         pixel_format_q;
	logic [GainW-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_32;
			gain_q         <= GainReset;
		end else if (cfg_we) begin
			case (cfg_addr)
				RegFormat: pixel_format_q <= pix_fmt_t'(cfg_wdata[1:0]);
				RegGain:   gain_q         <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Global advance: whole pipe moves when the output slot frees up
	logic adv;
	logic vld_s1, vld_s2, vld_s3;

	assign adv      = !vld_s3 || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage 1: input register
	logic [PixW-1:0] pix_s1;

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			pix_s1 <= s_tdata;
		end
	end

	// Gain and saturation
	chan3_t ch_scaled;

	pbs_scale u_scale (
		.fmt   (pixel_format_q),
		.gain  (gain_q),
		.pixel (pix_s1),
		.ch    (ch_scaled)
	);

	// Stage 2: scaled channels plus the original word (top byte / passthrough)
	chan3_t          ch_s2;
	logic [PixW-1:0] pix_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			ch_s2  <= ch_scaled;
			pix_s2 <= pix_s1;
		end
	end

	// Cube index and output word assembly
	logic [CubeW-1:0] cube_idx;
	logic [PixW-1:0]  pix_asm;

	pbs_cube u_cube (
		.fmt  (pixel_format_q),
		.ch   (ch_s2),
		.cube (cube_idx)
	);

	always_comb begin
		case (pixel_format_q)
			FMT_32:  pix_asm = {pix_s2[31:24], ch_s2[2], ch_s2[1], ch_s2[0]};
			FMT_24:  pix_asm = {8'h00, ch_s2[2], ch_s2[1], ch_s2[0]};
			FMT_16:  pix_asm = {16'h0000, ch_s2[2][4:0], ch_s2[1][5:0], ch_s2[0][4:0]};
			default: pix_asm = pix_s2;  // unused format code passes the pixel through
		endcase
	end

	// Stage 3: output register
	logic [PixW-1:0]  pix_s3;
	logic [CubeW-1:0] cube_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s3  <= pix_asm;
			cube_s3 <= cube_idx;
		end
	end

	assign m_tvalid = vld_s3;
	assign m_tdata  = {cube_s3, pix_s3};

	// Checks
	`PBS_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !vld_s3, s_tready)
	`PBS_ASSERT_NEXT(a_accept_loads_s1, clk, arst_n, s_tvalid && s_tready, vld_s1)
	`PBS_ASSERT_NOW(a_cube_range, clk, arst_n, vld_s3, cube_s3 <= 8'd215)
	`PBS_ASSERT_NOW(a_cube_only_24, clk, arst_n, vld_s3 && pixel_format_q != FMT_24,
		cube_s3 == '0)
	`PBS_ASSERT_NOW(a_565_upper_zero, clk, arst_n, vld_s3 && pixel_format_q == FMT_16,
		pix_s3[31:16] == 16'h0000)

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for pixel_brightness_scaler: gain, saturation and cube index checked on a stream.
module tb import pbs_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// Channel limits and cube rounding constants
	localparam int unsigned Max8      = 'hff;
	localparam int unsigned Max6      = 'h3f;
	localparam int unsigned Max5      = 'h1f;
	localparam int unsigned CubeBias  = 25;
	localparam int unsigned CubeStep  = 51;
	localparam int unsigned CubeMajor = 36;
	localparam int unsigned CubeMid   = 6;
	localparam logic [GainW-1:0] GainMax  = 11'd2047;
	localparam logic [GainW-1:0] GainZero = 11'd0;
	// Format code that the enum leaves out: pixel goes through untouched
	localparam logic [1:0] FmtUnused = 2'd3;

	localparam int unsigned IdlePct    = 24;
	localparam int unsigned PipeDepth  = 4;   // three stages plus margin
	localparam int unsigned HoldCycles = 80;
	localparam int unsigned StallLimit = 4000;
	localparam int unsigned RandPhases = 10;
	localparam int unsigned PhaseItems = 70;

	typedef struct packed {
		logic [CubeW-1:0] cube;
		logic [PixW-1:0]  pix;
	} pix_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [31:0]      s_tdata = '0;     // [31:0] pixel_in
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [39:0]      m_tdata;          // [31:0] pixel_out, [39:32] cube_index
	logic             cfg_we = 1'b0;
	logic [0:0]       cfg_addr = '0;
	logic [GainW-1:0] cfg_wdata = '0;

	// Shadow copy of the block's registers, updated at each write
	logic [1:0]       fmt_now = FMT_32;
	logic [GainW-1:0] gain_now = GainReset;

	pix_result_t pending_pixels[$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	// Idle controls for each side; cleared for the stretch with no idling
	bit send_idle_en = 1'b1;
	bit sink_idle_en = 1'b1;
	// Hold-off requests for the receiver, served in its own process
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;

	pixel_brightness_scaler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------- prediction ----------------

	// Q8 multiply, drop the fraction, clamp at the channel maximum
	function automatic int unsigned gain_chan(input int unsigned v, input int unsigned lim);
		int unsigned c;
		c = (v * gain_now) >> 8;
		return (c > lim) ? lim : c;
	endfunction

	// Round a scaled byte onto the six cube levels
	function automatic int unsigned cube_level(input int unsigned v);
		return (v + CubeBias) / CubeStep;
	endfunction

	function automatic pix_result_t scale_pixel(input logic [31:0] p);
		pix_result_t r;
		int unsigned c0, c1, c2;
		r.pix = p;
		r.cube = '0;
		case (fmt_now)
			FMT_32, FMT_24: begin
				c0 = gain_chan(p[7:0], Max8);
				c1 = gain_chan(p[15:8], Max8);
				c2 = gain_chan(p[23:16], Max8);
				r.pix = {8'h00, c2[7:0], c1[7:0], c0[7:0]};
				if (fmt_now == FMT_32) begin
					// alpha / palette flag byte rides along
					r.pix[31:24] = p[31:24];
				end else begin
					r.cube = 8'(cube_level(c0) * CubeMajor + cube_level(c1) * CubeMid
						+ cube_level(c2));
				end
			end
			FMT_16: begin
				c0 = gain_chan(p[4:0], Max5);
				c1 = gain_chan(p[10:5], Max6);
				c2 = gain_chan(p[15:11], Max5);
				r.pix = {16'h0000, c2[4:0], c1[5:0], c0[4:0]};
			end
			default: ;   // unused code: pixel passes unchanged, no cube index
		endcase
		return r;
	endfunction

	// ---------------- monitors ----------------

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// Input transfers: predict and queue the result
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pending_pixels.push_back(scale_pixel(s_tdata));
	end

	// Output transfers: compare against the oldest prediction
	always @(posedge clk) begin
		pix_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected transfer", m_tdata[31:0], '0);
			end else begin
				want = pending_pixels.pop_front();
				if (m_tdata[31:0] !== want.pix)
					report_mismatch("pixel_out", m_tdata[31:0], want.pix);
				if (m_tdata[39:32] !== want.cube)
					report_mismatch("cube_index", 32'(m_tdata[39:32]), 32'(want.cube));
			end
		end
	end

	// Receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= HoldCycles - 1;
			m_tready <= 1'b0;
		end else if (!sink_idle_en) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IdlePct);
		end
	end

	// Watchdog: too long with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------- driving ----------------

	// Offer one pixel; returns at the edge where it transfers, valid still high
	task automatic send_pixel(input logic [31:0] p);
		if (send_idle_en) begin
			while ($urandom_range(99) < IdlePct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
	endtask

	// Stop offering and wait until every predicted result has come out
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		// one edge first so the last input transfer is surely queued
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (PipeDepth) @(posedge clk);
	endtask

	// Register write on an idle pipe; shadow copy follows the write edge
	task automatic write_reg(input logic [0:0] idx, input logic [GainW-1:0] val);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == RegFormat)
			fmt_now = val[1:0];
		else
			gain_now = val;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [1:0] fmt, input logic [GainW-1:0] g);
		write_reg(RegFormat, {9'd0, fmt});
		write_reg(RegGain, g);
	endtask

	// ---------------- tests ----------------

	// Registers out of reset: 32-bit format at unity gain
	task automatic test_reset_defaults();
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h8001_7F80);
	endtask

	// 32-bit: gain extremes, top byte untouched
	task automatic test_fmt32_gain();
		set_mode(FMT_32, GainZero);
		send_pixel(32'hFFFF_FFFF);
		write_reg(RegGain, GainMax);
		send_pixel(32'hA501_0080);
		send_pixel(32'h0000_0000);
		write_reg(RegGain, 11'd128);
		send_pixel(32'h5AFF_0301);
	endtask

	// 24-bit: cube level thresholds on both sides, ignored top byte
	task automatic test_fmt24_cube();
		set_mode(FMT_24, GainReset);
		send_pixel(32'hFF1A_1900);   // levels 0/1 boundary
		send_pixel(32'h0080_4D4C);   // 1/2 and 2/3 boundaries
		send_pixel(32'hC3B3_B27F);   // 2/3, 3/4 boundaries
		send_pixel(32'h00FF_E6E5);   // 4/5 boundary, top level
		write_reg(RegGain, GainMax);
		send_pixel(32'h7F01_0102);   // small channels at top gain, cube index stays 0
	endtask

	// 16-bit 565: per-field saturation, upper half ignored
	task automatic test_fmt16_fields();
		set_mode(FMT_16, GainReset);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h1234_0000);
		write_reg(RegGain, GainMax);
		send_pixel(32'hABCD_0821);
		write_reg(RegGain, 11'd300);
		send_pixel(32'h0000_F7DE);
	endtask

	// Format code 3: straight pass-through whatever the gain
	task automatic test_unused_format();
		set_mode(FmtUnused, GainMax);
		send_pixel(32'hDEAD_BEEF);
		send_pixel(32'h0000_0001);
	endtask

	// Receiver holds off long while the sender keeps offering: pipe fills, input stalls
	task automatic test_backpressure();
		set_mode(FMT_24, 11'd333);
		send_idle_en = 1'b0;
		hold_requests++;
		@(posedge clk);
		repeat (30) send_pixel($urandom);
		send_idle_en = 1'b1;
	endtask

	// Random phases, each with its own format and gain
	task automatic test_random_phases();
		logic [GainW-1:0] g;
		for (int ph = 0; ph < RandPhases; ph++) begin
			case ($urandom_range(0, 4))
				0: g = GainZero;
				1: g = GainMax;
				2: g = GainReset;
				default: g = GainW'($urandom_range(0, 2047));
			endcase
			set_mode(2'($urandom_range(0, 3)), g);
			// one phase runs with no idling on either side
			send_idle_en = (ph != 4);
			sink_idle_en = (ph != 4);
			for (int i = 0; i < PhaseItems; i++)
				send_pixel($urandom);
		end
		send_idle_en = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_fmt32_gain();
		test_fmt24_cube();
		test_fmt16_fields();
		test_unused_format();
		test_backpressure();
		test_random_phases();

		drain_pipe();
		if (pending_pixels.size() != 0)
			report_mismatch("results missing", 32'(pending_pixels.size()), '0);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
